// File: src/kped_pkg.sv
package kped_pkg;

    localparam int ROW_W  = 3;
    localparam int COL_W  = 4;
    localparam int MODE_W = 2;

    localparam int ROWS_DEFAULT = 6;
    localparam int COLS_DEFAULT = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SHIFT  = 2'd1,
        MODE_ALPHA  = 2'd2
    } mode_t;

    typedef enum logic {
        EVENT_PRESS   = 1'b0,
        EVENT_RELEASE = 1'b1
    } event_kind_t;

    // Per-key status: released, or the press-time mode plus one
    localparam logic [MODE_W-1:0] STATUS_RELEASED = 2'd0;

    localparam logic [ROW_W-1:0] SHIFT_KEY_ROW = 3'd0;
    localparam logic [ROW_W-1:0] ALPHA_KEY_ROW = 3'd1;
    localparam logic [COL_W-1:0] MODIFIER_KEY_COL = 4'd0;

endpackage

// File: src/keypad_edge_detector_with_modifiers.sv
// Keypad edge detector with sticky modifiers. Each sample item (row, column,
// level) is checked against the stored state of that key: a released key read
// high gives a press event carrying the current sticky mode, a pressed key read
// low gives a release event carrying the mode stored at its press, anything
// else (no edge, or a key outside the ROWS x COLS matrix) gives no event.
// Flags report the sticky mode as it was before the item. One sample item is
// taken every cycle while the event side keeps up; an event is presented on
// the event channel after stage 1 and the output register: the accepting
// edge captures the sample together with the registered read of the per-key
// status memory, and the edge logic result is then loaded into the output
// register once it is free or being taken. Back-to-back samples of the same
// key are handled by a bypass around the memory. The status memory has a valid
// flop per key cleared by reset, so the block is ready straight out of reset.
module keypad_edge_detector_with_modifiers #(
    parameter int ROWS = kped_pkg::ROWS_DEFAULT,
    parameter int COLS = kped_pkg::COLS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  logic [kped_pkg::ROW_W-1:0]  row,
    input  logic [kped_pkg::COL_W-1:0]  column,
    input  logic                        level,

    output logic                        event_valid,
    input  logic                        event_ready,
    output logic                        event_kind,
    output logic [kped_pkg::ROW_W-1:0]  key_row,
    output logic [kped_pkg::COL_W-1:0]  key_column,
    output logic [kped_pkg::MODE_W-1:0] key_mode,
    output logic                        shift_flag,
    output logic                        alpha_flag
);

    localparam int KEYS  = ROWS * COLS;
    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    // Status store
    logic [kped_pkg::MODE_W-1:0] status_mem [KEYS];
    logic [KEYS-1:0]             status_vld_reg;

    // Stage 1: captured sample and registered read
    logic                        s1_valid_reg;
    logic [kped_pkg::ROW_W-1:0]  s1_row_reg;
    logic [kped_pkg::COL_W-1:0]  s1_col_reg;
    logic                        s1_level_reg;
    logic                        s1_in_range_reg;
    logic [IDX_W-1:0]            s1_idx_reg;
    logic [kped_pkg::MODE_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;
    logic                        byp_hit_reg;
    logic [kped_pkg::MODE_W-1:0] byp_data_reg;

    // Sticky mode
    kped_pkg::mode_t             mode_reg;
    kped_pkg::mode_t             mode_next;

    // Output register
    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [kped_pkg::ROW_W-1:0]  out_row_reg;
    logic [kped_pkg::COL_W-1:0]  out_col_reg;
    logic [kped_pkg::MODE_W-1:0] out_mode_reg;
    logic                        out_shift_reg;
    logic                        out_alpha_reg;

    logic                        accept;
    logic                        s2_adv;
    logic                        in_range;
    logic [IDX_W-1:0]            idx;
    logic [kped_pkg::MODE_W-1:0] stored;
    logic                        press;
    logic                        release_edge;
    logic                        has_event;
    logic                        wr_en;
    logic [kped_pkg::MODE_W-1:0] wr_data;

    assign s2_adv       = s1_valid_reg && (!out_valid_reg || event_ready);
    assign sample_ready = !s1_valid_reg || s2_adv;
    assign accept       = sample_valid && sample_ready;

    assign in_range = (int'(row) < ROWS) && (int'(column) < COLS);
    assign idx      = IDX_W'(int'(row) * COLS + int'(column));

    // Newest write wins over the memory read
    assign stored = byp_hit_reg ? byp_data_reg :
                    (rd_vld_reg ? rd_data_reg : kped_pkg::STATUS_RELEASED);

    assign press        = s1_in_range_reg && (stored == kped_pkg::STATUS_RELEASED)
                          && s1_level_reg;
    assign release_edge = s1_in_range_reg && (stored != kped_pkg::STATUS_RELEASED)
                          && !s1_level_reg;
    assign has_event    = press || release_edge;
    assign wr_en        = s2_adv && has_event;
    assign wr_data      = press ? (kped_pkg::MODE_W'(mode_reg) + 2'd1)
                                : kped_pkg::STATUS_RELEASED;

    always_comb
    begin
        mode_next = mode_reg;
        if (press)
        begin
            if (s1_col_reg == kped_pkg::MODIFIER_KEY_COL
                && s1_row_reg == kped_pkg::SHIFT_KEY_ROW)
            begin
                mode_next = kped_pkg::MODE_SHIFT;
            end
            else if (s1_col_reg == kped_pkg::MODIFIER_KEY_COL
                     && s1_row_reg == kped_pkg::ALPHA_KEY_ROW)
            begin
                mode_next = kped_pkg::MODE_ALPHA;
            end
            else
            begin
                mode_next = kped_pkg::MODE_NORMAL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            status_mem[s1_idx_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= status_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            status_vld_reg[s1_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg      <= row;
            s1_col_reg      <= column;
            s1_level_reg    <= level;
            s1_in_range_reg <= in_range;
            s1_idx_reg      <= idx;
            rd_vld_reg      <= status_vld_reg[idx] || (wr_en && s1_idx_reg == idx);
            byp_hit_reg     <= wr_en && (s1_idx_reg == idx);
            byp_data_reg    <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= kped_pkg::MODE_NORMAL;
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            mode_reg      <= mode_next;
            out_valid_reg <= has_event;
        end
        else if (event_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_kind_reg  <= press ? kped_pkg::EVENT_PRESS : kped_pkg::EVENT_RELEASE;
            out_row_reg   <= s1_row_reg;
            out_col_reg   <= s1_col_reg;
            out_mode_reg  <= press ? kped_pkg::MODE_W'(mode_reg) : (stored - 2'd1);
            out_shift_reg <= (mode_reg == kped_pkg::MODE_SHIFT);
            out_alpha_reg <= (mode_reg == kped_pkg::MODE_ALPHA);
        end
    end

    assign event_valid = out_valid_reg;
    assign event_kind  = out_kind_reg;
    assign key_row     = out_row_reg;
    assign key_column  = out_col_reg;
    assign key_mode    = out_mode_reg;
    assign shift_flag  = out_shift_reg;
    assign alpha_flag  = out_alpha_reg;

`ifndef SYNTHESIS
    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> (key_mode != 2'd3) && !(shift_flag && alpha_flag))
        else $error("illegal mode on event item");

    a_shift_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && press && s1_row_reg == kped_pkg::SHIFT_KEY_ROW
         && s1_col_reg == kped_pkg::MODIFIER_KEY_COL)
        |=> (mode_reg == kped_pkg::MODE_SHIFT))
        else $error("shift key press did not set shift mode");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (s1_valid_reg && out_valid_reg && !event_ready))
        else $error("sample stalled with room in the pipeline");

    a_write_clears_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && release_edge) |=> status_vld_reg[$past(s1_idx_reg)])
        else $error("release not recorded in status store");
`endif

endmodule
